// File: design/drrip_replacement_policy_defines.svh
// assertion macros for the drrip replacement policy checker
// depends on nothing; expects signals named clock and reset where used
`ifndef DRRIP_REPLACEMENT_POLICY_DEFINES_SVH
`define DRRIP_REPLACEMENT_POLICY_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DRRIP_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("drrip check failed");

// next-cycle implication, disabled during reset
`define DRRIP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("drrip check failed");

`endif

// File: design/drrip_pkg.sv
// constants, types and helper functions for the drrip replacement policy
// no dependencies; used by every other file of the block except the defines header
package drrip_pkg;

   // cache geometry and policy sizes
   localparam int NUM_SETS     = 2048;
   localparam int NUM_WAYS     = 16;
   localparam int NUM_LEADERS  = 64;
   localparam int BIMODAL_ODDS = 32;

   // field and storage widths
   localparam int SET_W         = $clog2(NUM_SETS);
   localparam int WAY_W         = $clog2(NUM_WAYS);
   localparam int DRAW_W        = $clog2(BIMODAL_ODDS);
   localparam int RRPV_W        = 2;
   localparam int DUEL_W        = 10;
   localparam int LEADER_STRIDE = NUM_SETS / NUM_LEADERS;
   localparam int STRIDE_W      = $clog2(LEADER_STRIDE);
   localparam int LEADER_W      = SET_W - STRIDE_W;

   // re-reference values
   localparam logic [RRPV_W-1:0] RRPV_HIT  = 2'd0;
   localparam logic [RRPV_W-1:0] RRPV_NEAR = 2'd2;
   localparam logic [RRPV_W-1:0] RRPV_MAX  = 2'd3;

   // dueling counter limits
   localparam logic [DUEL_W-1:0] DUEL_BOTTOM = 10'd0;
   localparam logic [DUEL_W-1:0] DUEL_MID    = 10'd512;
   localparam logic [DUEL_W-1:0] DUEL_TOP    = 10'd1023;

   // set roles
   localparam logic [1:0] KIND_FOLLOWER = 2'd0;
   localparam logic [1:0] KIND_SRRIP    = 2'd1;
   localparam logic [1:0] KIND_BRRIP    = 2'd2;

   typedef logic [NUM_WAYS-1:0][RRPV_W-1:0] row_type;

   localparam row_type ROW_RESET = {NUM_WAYS{RRPV_MAX}};

   // controller to datapath
   typedef struct packed {
      logic clear_wr;
      logic accept;
      logic commit;
   } drrip_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic out_free;
   } drrip_status_type;

   // leaders sit on every stride-th set; lower half srrip, upper half brrip
   function automatic logic [1:0] leader_kind(input logic [SET_W-1:0] s);
      logic [LEADER_W-1:0] idx;
      idx = s[SET_W-1:STRIDE_W];
      if (s[STRIDE_W-1:0] != '0) begin
         return KIND_FOLLOWER;
      end else if (!idx[LEADER_W-1]) begin
         return KIND_SRRIP;
      end else begin
         return KIND_BRRIP;
      end
   endfunction

endpackage

// File: design/drrip_interfaces.sv
// valid/ready channel interfaces for the drrip request and response items
// depends on drrip_pkg for field widths
interface drrip_req_if;
   logic                        valid;
   logic                        ready;
   logic [drrip_pkg::SET_W-1:0]  set_index;
   logic                        hit;
   logic [drrip_pkg::WAY_W-1:0]  hit_way;
   logic [drrip_pkg::DRAW_W-1:0] bimodal_draw;

   modport source (output valid, set_index, hit, hit_way, bimodal_draw, input ready);
   modport sink (input valid, set_index, hit, hit_way, bimodal_draw, output ready);
endinterface

interface drrip_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [drrip_pkg::WAY_W-1:0]   chosen_way;
   logic [drrip_pkg::RRPV_W-1:0]  written_value;
   logic                          used_srrip;

   modport source (output valid, chosen_way, written_value, used_srrip, input ready);
   modport sink (input valid, chosen_way, written_value, used_srrip, output ready);
endinterface

// File: design/drrip_ctrl.sv
// controller state machine: clearing pass, item intake and commit sequencing
// depends on drrip_pkg for the command and status types
module drrip_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  drrip_pkg::drrip_status_type status,
   output drrip_pkg::drrip_cmd_type    cmd
);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_CALC  = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      cmd.clear_wr = 1'b0;
      cmd.accept   = 1'b0;
      cmd.commit   = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_CALC;
            end
         end
         ST_CALC: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: design/drrip_datapath.sv
// datapath: row memory, dueling counter, victim search and response register
// depends on drrip_pkg for widths, constants and the leader decode
module drrip_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  drrip_pkg::drrip_cmd_type     cmd,
   output drrip_pkg::drrip_status_type  status,
   input  logic [drrip_pkg::SET_W-1:0]  req_set_index,
   input  logic                         req_hit,
   input  logic [drrip_pkg::WAY_W-1:0]  req_hit_way,
   input  logic [drrip_pkg::DRAW_W-1:0] req_bimodal_draw,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output logic [drrip_pkg::WAY_W-1:0]  rsp_chosen_way,
   output logic [drrip_pkg::RRPV_W-1:0] rsp_written_value,
   output logic                         rsp_used_srrip
);

   drrip_pkg::row_type mem [drrip_pkg::NUM_SETS];

   logic [drrip_pkg::SET_W-1:0]  clear_addr_ff;
   logic [drrip_pkg::SET_W-1:0]  set_ff;
   logic                         hit_ff;
   logic [drrip_pkg::WAY_W-1:0]  hit_way_ff;
   logic [drrip_pkg::DRAW_W-1:0] draw_ff;
   drrip_pkg::row_type           row_ff;
   logic [drrip_pkg::DUEL_W-1:0] duel_ff;
   logic [drrip_pkg::DUEL_W-1:0] duel_in;
   logic                         rsp_valid_ff;
   logic [drrip_pkg::WAY_W-1:0]  rsp_way_ff;
   logic [drrip_pkg::RRPV_W-1:0] rsp_value_ff;
   logic                         rsp_srrip_ff;

   logic                         any3;
   logic                         any2;
   logic                         any1;
   logic [drrip_pkg::RRPV_W-1:0] row_max;
   logic [drrip_pkg::RRPV_W-1:0] age_add;
   drrip_pkg::row_type           aged;
   drrip_pkg::row_type           new_row;
   logic [drrip_pkg::WAY_W-1:0]  victim;
   logic [1:0]                   kind;
   logic                         srrip;
   logic [drrip_pkg::RRPV_W-1:0] fill_value;
   logic [drrip_pkg::WAY_W-1:0]  out_way;
   logic [drrip_pkg::RRPV_W-1:0] out_value;
   logic                         out_srrip;

   // status back to the controller
   assign status.clear_last = (clear_addr_ff == '1);
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   // clearing pass address
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_addr_ff <= '0;
      end else if (cmd.clear_wr) begin
         clear_addr_ff <= clear_addr_ff + 1'b1;
      end
   end

   // row memory: one write port, registered read at intake
   always_ff @(posedge clock) begin
      if (cmd.clear_wr) begin
         mem[clear_addr_ff] <= drrip_pkg::ROW_RESET;
      end else if (cmd.commit) begin
         mem[set_ff] <= new_row;
      end
      if (cmd.accept) begin
         row_ff <= mem[req_set_index];
      end
   end

   // item fields held for the update cycle
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         set_ff     <= req_set_index;
         hit_ff     <= req_hit;
         hit_way_ff <= req_hit_way;
         draw_ff    <= req_bimodal_draw;
      end
   end

   // row maximum and ageing
   always_comb begin
      any3 = 1'b0;
      any2 = 1'b0;
      any1 = 1'b0;
      for (int w = 0; w < drrip_pkg::NUM_WAYS; w++) begin
         any3 = any3 | (row_ff[w] == 2'd3);
         any2 = any2 | (row_ff[w] == 2'd2);
         any1 = any1 | (row_ff[w] == 2'd1);
      end
      if (any3) begin
         row_max = 2'd3;
      end else if (any2) begin
         row_max = 2'd2;
      end else if (any1) begin
         row_max = 2'd1;
      end else begin
         row_max = 2'd0;
      end
      age_add = drrip_pkg::RRPV_MAX - row_max;
      for (int w = 0; w < drrip_pkg::NUM_WAYS; w++) begin
         aged[w] = row_ff[w] + age_add;
      end
   end

   // lowest way at the distant value
   always_comb begin
      victim = '0;
      for (int w = drrip_pkg::NUM_WAYS - 1; w >= 0; w--) begin
         if (aged[w] == drrip_pkg::RRPV_MAX) begin
            victim = drrip_pkg::WAY_W'(w);
         end
      end
   end

   // insertion policy from set role and dueling counter
   always_comb begin
      kind = drrip_pkg::leader_kind(set_ff);
      unique case (kind)
         drrip_pkg::KIND_SRRIP: srrip = 1'b1;
         drrip_pkg::KIND_BRRIP: srrip = 1'b0;
         default:               srrip = (duel_ff >= drrip_pkg::DUEL_MID);
      endcase
      if (srrip || (draw_ff == '0)) begin
         fill_value = drrip_pkg::RRPV_NEAR;
      end else begin
         fill_value = drrip_pkg::RRPV_MAX;
      end
   end

   // updated row and result fields
   always_comb begin
      if (hit_ff) begin
         new_row             = row_ff;
         new_row[hit_way_ff] = drrip_pkg::RRPV_HIT;
         out_way             = hit_way_ff;
         out_value           = drrip_pkg::RRPV_HIT;
         out_srrip           = 1'b0;
      end else begin
         new_row         = aged;
         new_row[victim] = fill_value;
         out_way         = victim;
         out_value       = fill_value;
         out_srrip       = srrip;
      end
   end

   // saturating dueling counter, moved by leader misses
   always_comb begin
      duel_in = duel_ff;
      if (cmd.commit && !hit_ff) begin
         if (kind == drrip_pkg::KIND_SRRIP && duel_ff != drrip_pkg::DUEL_BOTTOM) begin
            duel_in = duel_ff - 1'b1;
         end else if (kind == drrip_pkg::KIND_BRRIP && duel_ff != drrip_pkg::DUEL_TOP) begin
            duel_in = duel_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duel_ff <= drrip_pkg::DUEL_MID;
      end else begin
         duel_ff <= duel_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_way_ff   <= out_way;
         rsp_value_ff <= out_value;
         rsp_srrip_ff <= out_srrip;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_chosen_way    = rsp_way_ff;
   assign rsp_written_value = rsp_value_ff;
   assign rsp_used_srrip    = rsp_srrip_ff;

endmodule

// File: design/drrip_replacement_policy.sv
// top level of the drrip replacement policy: controller plus datapath
// depends on drrip_pkg, drrip_interfaces, drrip_ctrl and drrip_datapath
//
// Each request item names a cache set and says hit or miss; one response item
// comes back with the chosen way, the re-reference value written and whether
// SRRIP insertion applied. At intake the set's row is read from the row
// memory into a register; the update writes the row back and loads the
// response register. A new item is taken in the cycle after that update,
// while the previous response may still wait downstream; an update waits
// only if the response register is still full. After reset the row memory
// is cleared one set a cycle, all 2048 sets, and no request is taken
// until that clearing pass ends.
module drrip_replacement_policy (
   input logic         clock,
   input logic         reset,
   drrip_req_if.sink   req_if,
   drrip_rsp_if.source rsp_if
);

   drrip_pkg::drrip_cmd_type    cmd;
   drrip_pkg::drrip_status_type status;

   // sequencing
   drrip_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // storage and arithmetic
   drrip_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_set_index     (req_if.set_index),
      .req_hit           (req_if.hit),
      .req_hit_way       (req_if.hit_way),
      .req_bimodal_draw  (req_if.bimodal_draw),
      .rsp_ready         (rsp_if.ready),
      .rsp_valid         (rsp_if.valid),
      .rsp_chosen_way    (rsp_if.chosen_way),
      .rsp_written_value (rsp_if.written_value),
      .rsp_used_srrip    (rsp_if.used_srrip)
   );

endmodule

// File: design/drrip_checker.sv
// port-level checks for the drrip replacement policy, bound to the top level
// depends on drrip_pkg and drrip_replacement_policy_defines.svh
`include "drrip_replacement_policy_defines.svh"

module drrip_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [drrip_pkg::WAY_W-1:0]  rsp_chosen_way,
   input logic [drrip_pkg::RRPV_W-1:0] rsp_written_value,
   input logic                         rsp_used_srrip
);

   logic                                        rsp_stalled;
   logic                                        rsp_near;
   logic [drrip_pkg::WAY_W+drrip_pkg::RRPV_W:0] rsp_fields;

   // response item summaries
   assign rsp_stalled = rsp_valid && !rsp_ready;
   assign rsp_near    = (rsp_written_value == drrip_pkg::RRPV_NEAR);
   assign rsp_fields  = {rsp_chosen_way, rsp_written_value, rsp_used_srrip};

   // one item at a time: no intake straight after an intake
   `DRRIP_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready)

   // clearing pass follows reset, nothing pending out
   `DRRIP_ASSERT_IMP(a_clear_after_reset, $fell(reset), !req_ready && !rsp_valid)

   // srrip fills always go in at the near value
   `DRRIP_ASSERT_IMP(a_srrip_near, rsp_valid && rsp_used_srrip, rsp_near)

   // a stalled response item holds
   `DRRIP_ASSERT_NEXT(a_rsp_hold, rsp_stalled, rsp_valid && $stable(rsp_fields))

endmodule

bind drrip_replacement_policy drrip_checker u_drrip_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_if.valid),
   .req_ready         (req_if.ready),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_chosen_way    (rsp_if.chosen_way),
   .rsp_written_value (rsp_if.written_value),
   .rsp_used_srrip    (rsp_if.used_srrip)
);
